// ===== rtl/core/dsjc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dsjc_pkg
// Shared types and constants of the dual servo jog controller.
// ----------------------------------------------------------------------------
package dsjc_pkg;

    // field widths
    localparam int ModeW    = 2;
    localparam int LevelW   = 11;
    localparam int AngleW   = 13;
    localparam int CfgAngW  = 12;
    localparam int CountW   = 16;
    localparam int CfgIdxW  = 2;
    localparam int SumW     = 15;

    typedef logic [ModeW-1:0]          mode_t;
    typedef logic signed [LevelW-1:0]  level_t;
    typedef logic signed [AngleW-1:0]  angle_t;
    typedef logic [CfgAngW-1:0]        cfg_ang_t;
    typedef logic [CountW-1:0]         count_t;
    typedef logic [CfgIdxW-1:0]        cfg_idx_t;
    typedef logic signed [SumW-1:0]    ang_sum_t;

    // operating modes
    localparam mode_t MODE_JOG  = 2'd0;
    localparam mode_t MODE_STOP = 2'd1;

    // configuration register indexes
    localparam cfg_idx_t REG_STEP_SIZE  = 2'd0;
    localparam cfg_idx_t REG_TRAVEL_LIM = 2'd1;
    localparam cfg_idx_t REG_HOME_RIGHT = 2'd2;
    localparam cfg_idx_t REG_HOME_LEFT  = 2'd3;

    // reset values of the configuration registers
    localparam cfg_ang_t STEP_SIZE_RST  = 12'd16;
    localparam cfg_ang_t TRAVEL_LIM_RST = 12'd2880;

    // remote level thresholds
    localparam level_t SWITCH_THRESHOLD = 11'sd600;
    localparam level_t WHEEL_THRESHOLD  = 11'sd100;

    // angle to counts: floor(angle*5/72), done as ((n + 72*300) >> 3) / 9 - 300
    localparam logic signed [16:0] DIV_OFFSET  = 17'sd21600;
    localparam logic [12:0]        RECIP_NINE  = 13'd7282;
    localparam logic signed [10:0] QUOT_OFFSET = 11'sd300;

    // per-servo stepping control
    typedef struct packed {
        logic     step;
        logic     increase;
    } jog_ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/core/dsjc_jog_step.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dsjc_jog_step
// Steps one servo angle up or down and clamps it to its travel window.
// ----------------------------------------------------------------------------
module dsjc_jog_step (
    input  wire dsjc_pkg::angle_t    angle,
    input  wire dsjc_pkg::cfg_ang_t  step_size,
    input  wire dsjc_pkg::jog_ctrl_t ctrl,
    input  wire dsjc_pkg::ang_sum_t  lo_bound,
    input  wire dsjc_pkg::ang_sum_t  hi_bound,
    output dsjc_pkg::angle_t         angle_next
);
    import dsjc_pkg::*;

    ang_sum_t angle_ext;
    ang_sum_t step_ext;
    ang_sum_t moved;
    ang_sum_t clamped;

    // add or subtract one step
    always_comb begin
        angle_ext = ang_sum_t'(angle);
        step_ext  = ang_sum_t'({1'b0, step_size});
        moved     = ctrl.increase ? (angle_ext + step_ext) : (angle_ext - step_ext);
    end

    // clamp to the window, upper bound first
    always_comb begin
        clamped = moved;
        if (clamped > hi_bound) begin
            clamped = hi_bound;
        end
        if (clamped < lo_bound) begin
            clamped = lo_bound;
        end
        angle_next = ctrl.step ? clamped[AngleW-1:0] : angle;
    end

endmodule
`default_nettype wire

// ===== rtl/core/dsjc_compare_map.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dsjc_compare_map
// Maps a servo angle to a timer compare value around its home count.
// ----------------------------------------------------------------------------
module dsjc_compare_map (
    input  wire dsjc_pkg::angle_t angle,
    input  wire dsjc_pkg::count_t home,
    output dsjc_pkg::count_t      compare
);
    import dsjc_pkg::*;

    logic signed [16:0] scaled;
    logic signed [16:0] shifted;
    logic [12:0]        eighth;
    logic [25:0]        product;
    logic signed [10:0] quot;
    logic signed [17:0] total;

    // offset keeps the dividend positive so truncation is a floor
    always_comb begin
        scaled  = 17'(angle) * 17'sd5;
        shifted = scaled + DIV_OFFSET;
        eighth  = shifted[15:3];
        product = {13'd0, eighth} * {13'd0, RECIP_NINE};
        quot    = $signed({1'b0, product[25:16]}) - QUOT_OFFSET;
        total   = $signed({2'b00, home}) + 18'(quot);
    end

    // saturate to the counter range
    always_comb begin
        if (total < 18'sd0) begin
            compare = '0;
        end else if (total[17:16] != 2'b00) begin
            compare = '1;
        end else begin
            compare = total[15:0];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/dual_servo_jog_controller.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dual_servo_jog_controller
// Remote jog control of two servos producing timer compare values.
// ----------------------------------------------------------------------------
// Each item is one control tick. An item is captured in an input register and
// finished when it advances out of it: the angle step, clamp and angle-to-count
// scaling then update the servo state and load the result register; the input
// register frees in that same cycle, so one item per cycle is sustained while
// the result side keeps up. A jog or stop item gives one result holding both
// compare values; other modes give none and change nothing. Configuration
// writes are taken every cycle and must only be made while no item is in
// flight.
module dual_servo_jog_controller (
    input  wire                     aclk,
    input  wire                     aresetn,
    // configuration
    input  wire                     cfg_valid,
    output logic                    cfg_ready,
    input  wire dsjc_pkg::cfg_idx_t cfg_index,
    input  wire [15:0]              cfg_data,
    // input items
    input  wire                     s_valid,
    output logic                    s_ready,
    input  wire dsjc_pkg::mode_t    s_mode,
    input  wire dsjc_pkg::level_t   s_switch_level,
    input  wire dsjc_pkg::level_t   s_wheel_level,
    // result items
    output logic                    m_valid,
    input  wire                     m_ready,
    output dsjc_pkg::count_t        m_compare_right,
    output dsjc_pkg::count_t        m_compare_left
);
    import dsjc_pkg::*;

    // configuration registers
    cfg_ang_t step_size_reg;
    cfg_ang_t travel_limit_reg;
    count_t   home_right_reg;
    count_t   home_left_reg;

    // input stage
    logic     in_valid_reg;
    mode_t    mode_reg;
    level_t   switch_reg;
    level_t   wheel_reg;

    // servo state
    angle_t   angle_right_reg;
    angle_t   angle_left_reg;
    count_t   held_right_reg;
    count_t   held_left_reg;

    // result stage
    logic     m_valid_reg;
    count_t   compare_right_reg;
    count_t   compare_left_reg;

    logic      is_jog;
    logic      is_stop;
    logic      has_result;
    logic      advance;
    logic      pick_right;
    logic      pick_left;
    logic      wheel_up;
    logic      wheel_down;
    jog_ctrl_t ctrl_right;
    jog_ctrl_t ctrl_left;
    ang_sum_t  limit_pos;
    ang_sum_t  limit_neg;
    angle_t    angle_right_next;
    angle_t    angle_left_next;
    count_t    map_right;
    count_t    map_left;
    count_t    held_right_next;
    count_t    held_left_next;

    // configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_size_reg    <= STEP_SIZE_RST;
            travel_limit_reg <= TRAVEL_LIM_RST;
            home_right_reg   <= '0;
            home_left_reg    <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_STEP_SIZE:  step_size_reg    <= cfg_data[CfgAngW-1:0];
                REG_TRAVEL_LIM: travel_limit_reg <= cfg_data[CfgAngW-1:0];
                REG_HOME_RIGHT: home_right_reg   <= cfg_data;
                REG_HOME_LEFT:  home_left_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // item decode
    always_comb begin
        is_jog     = (mode_reg == MODE_JOG);
        is_stop    = (mode_reg == MODE_STOP);
        has_result = is_jog || is_stop;
        advance    = in_valid_reg && (!has_result || !m_valid_reg || m_ready);
        s_ready    = !in_valid_reg || advance;
        pick_right = (switch_reg >= -SWITCH_THRESHOLD);
        pick_left  = (switch_reg <= SWITCH_THRESHOLD);
        wheel_up   = (wheel_reg > WHEEL_THRESHOLD);
        wheel_down = (wheel_reg < -WHEEL_THRESHOLD);
        ctrl_right.step     = is_jog && pick_right && (wheel_up || wheel_down);
        ctrl_right.increase = wheel_down;
        ctrl_left.step      = is_jog && pick_left && (wheel_up || wheel_down);
        ctrl_left.increase  = wheel_up;
        limit_pos  = ang_sum_t'({1'b0, travel_limit_reg});
        limit_neg  = -limit_pos;
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            mode_reg   <= s_mode;
            switch_reg <= s_switch_level;
            wheel_reg  <= s_wheel_level;
        end
    end

    // angle stepping, right servo in [0, limit], left in [-limit, 0]
    dsjc_jog_step u_step_right (
        .angle      (angle_right_reg),
        .step_size  (step_size_reg),
        .ctrl       (ctrl_right),
        .lo_bound   ('0),
        .hi_bound   (limit_pos),
        .angle_next (angle_right_next)
    );

    dsjc_jog_step u_step_left (
        .angle      (angle_left_reg),
        .step_size  (step_size_reg),
        .ctrl       (ctrl_left),
        .lo_bound   (limit_neg),
        .hi_bound   ('0),
        .angle_next (angle_left_next)
    );

    // angle to compare counts
    dsjc_compare_map u_map_right (
        .angle   (angle_right_next),
        .home    (home_right_reg),
        .compare (map_right)
    );

    dsjc_compare_map u_map_left (
        .angle   (angle_left_next),
        .home    (home_left_reg),
        .compare (map_left)
    );

    // held compare selection
    always_comb begin
        held_right_next = held_right_reg;
        held_left_next  = held_left_reg;
        if (is_stop) begin
            held_right_next = home_right_reg;
            held_left_next  = home_left_reg;
        end else begin
            if (ctrl_right.step) begin
                held_right_next = map_right;
            end
            if (ctrl_left.step) begin
                held_left_next = map_left;
            end
        end
    end

    // servo state update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            angle_right_reg <= '0;
            angle_left_reg  <= '0;
            held_right_reg  <= '0;
            held_left_reg   <= '0;
        end else if (advance && has_result) begin
            angle_right_reg <= angle_right_next;
            angle_left_reg  <= angle_left_next;
            held_right_reg  <= held_right_next;
            held_left_reg   <= held_left_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance && has_result) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && has_result) begin
            compare_right_reg <= held_right_next;
            compare_left_reg  <= held_left_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_compare_right = compare_right_reg;
    assign m_compare_left  = compare_left_reg;

    // right angle never below zero, left angle never above zero
    a_angle_window: assert property (@(posedge aclk) disable iff (!aresetn)
        !angle_right_reg[AngleW-1] && (angle_left_reg[AngleW-1] || angle_left_reg == '0))
        else $error("servo angle left its travel window");

    // a stop item recentres both held compares
    a_stop_home: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && is_stop) |=> (held_right_reg == $past(home_right_reg)
                                  && held_left_reg == $past(home_left_reg)))
        else $error("stop item did not return compares to home");

    // an item with no result never loads the result register
    a_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && !has_result && !m_valid_reg) |=> !m_valid_reg)
        else $error("result raised for an item of another mode");

    // the result shown matches the held compares
    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (compare_right_reg == held_right_reg
                         && compare_left_reg == held_left_reg))
        else $error("result differs from held compare state");

endmodule
`default_nettype wire
